// File: sv/sobm_pkg.sv
// Shared types and constants for the RGB Sobel edge magnitude block.
// Used by the front end, the back end and the top level; depends on nothing else.
package sobm_pkg;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pix_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_edge;
    logic [7:0] green_edge;
    logic [7:0] blue_edge;
    logic       frame_done;
  } out_item_t;

  // One window column: pixels of the row above, the centre row and the row below.
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_t;

  typedef struct packed {
    col_t lft;
    col_t ctr;
    col_t rgt;
    logic done;
  } win_item_t;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic CFG_WIDTH_IDX  = 1'b0;
  localparam logic CFG_HEIGHT_IDX = 1'b1;

  localparam logic [10:0] WIDTH_RESET  = 11'd640;
  localparam logic [11:0] HEIGHT_RESET = 12'd480;

  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 16;
  localparam int ROOT_BITS = 8;

endpackage

// File: sv/sobm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module sobm_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/sobm_fifo.sv
// Small flop-based first-in first-out queue with a combinational head.
// No dependencies; room is guaranteed by the writer's credit count.
module sobm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]    count_r, count_nxt;

  assign empty = (count_r == NW'(0));
  assign rdata = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? PW'(0) : wr_ptr_r + PW'(1);
    end
    if (pop && !empty) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? PW'(0) : rd_ptr_r + PW'(1);
    end
    if (push && !(pop && !empty)) begin
      count_nxt = count_r + NW'(1);
    end else if (!push && pop && !empty) begin
      count_nxt = count_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: sv/sobm_front.sv
// Front end: raster position, two-row line store and 3x3 window assembly.
// Depends on sobm_pkg and sobm_ram; pushes finished windows to the middle queue.
module sobm_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         restart,
  input  logic [$clog2(MAX_WIDTH)-1:0] width_m1,
  input  logic [12:0]                  height,
  input  logic                         in_push,
  output logic                         in_full,
  input  sobm_pkg::in_item_t           in_data,
  output logic                         q_push,
  output sobm_pkg::win_item_t          q_data,
  input  logic                         q_pop
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int KW = $clog2(sobm_pkg::MID_DEPTH + 1);

  logic [CW-1:0] col_r, col_nxt;
  logic [12:0]   row_r, row_nxt;
  logic [KW-1:0] cnt_r, cnt_nxt;
  logic          acc, emit0, done0;

  // Stage 1 registers
  logic              s1_v_r;
  sobm_pkg::pix_t    s1_pix_r;
  logic [CW-1:0]     s1_col_r;
  logic              s1_emit_r, s1_done_r;
  logic              s1_mt_r, s1_mm_r, s1_mb_r;
  logic              s1_ge1_r, s1_ge2_r, s1_wge2_r;

  logic              fwd_r;
  logic [47:0]       fwd_data_r;
  logic [47:0]       ram_rdata, rd_eff, wdata;
  sobm_pkg::pix_t    above, above2, pix0;
  sobm_pkg::col_t    cur, prev1_r, prev2_r;

  assign acc     = in_push && !in_full;
  assign in_full = (cnt_r >= KW'(sobm_pkg::MID_DEPTH));
  assign emit0   = (row_r >= 13'd2) || (row_r == 13'd1 && col_r != CW'(0));
  assign done0   = (row_r == height + 13'd1) && (col_r == CW'(0));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (acc) begin
      if (done0) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_r == width_m1) begin
        col_nxt = '0;
        row_nxt = row_r + 13'd1;
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if ((acc && emit0) && !q_pop) begin
      cnt_nxt = cnt_r + KW'(1);
    end else if (!(acc && emit0) && q_pop) begin
      cnt_nxt = cnt_r - KW'(1);
    end
  end

  always_comb begin
    pix0 = '0;
    if (in_data.operation == sobm_pkg::OP_PIXEL) begin
      pix0 = '{r: in_data.red_in, g: in_data.green_in, b: in_data.blue_in};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      cnt_r  <= '0;
      s1_v_r <= 1'b0;
      fwd_r  <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      cnt_r  <= cnt_nxt;
      s1_v_r <= acc;
      // A read issued while the same column is being written sees old data.
      fwd_r  <= acc && s1_v_r && (col_r == s1_col_r);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= wdata;
    if (acc) begin
      s1_pix_r  <= pix0;
      s1_col_r  <= col_r;
      s1_emit_r <= emit0;
      s1_done_r <= done0;
      s1_mt_r   <= (row_r >= 13'd2) && (row_r < height + 13'd2);
      s1_mm_r   <= (row_r >= 13'd1) && (row_r < height + 13'd1);
      s1_mb_r   <= (row_r < height);
      s1_ge1_r  <= (col_r >= CW'(1));
      s1_ge2_r  <= (col_r >= CW'(2));
      s1_wge2_r <= (width_m1 != CW'(0));
    end
    if (s1_v_r) begin
      prev2_r <= prev1_r;
      prev1_r <= cur;
    end
  end

  // Each column word holds the pixel one row up and the pixel two rows up.
  sobm_ram #(
    .WIDTH (48),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (s1_v_r),
    .waddr (s1_col_r),
    .wdata (wdata),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  assign rd_eff = fwd_r ? fwd_data_r : ram_rdata;
  assign above  = rd_eff[47:24];
  assign above2 = rd_eff[23:0];
  assign wdata  = {s1_pix_r, above};

  always_comb begin
    cur.top = s1_mt_r ? above2 : '0;
    cur.mid = s1_mm_r ? above : '0;
    cur.bot = s1_mb_r ? s1_pix_r : '0;
    q_data.done = s1_done_r;
    q_data.ctr  = prev1_r;
    if (s1_ge1_r) begin
      q_data.lft = s1_ge2_r ? prev2_r : '0;
      q_data.rgt = cur;
    end else begin
      // Column zero closes the previous row: its right neighbour is off the frame.
      q_data.lft = s1_wge2_r ? prev2_r : '0;
      q_data.rgt = '0;
    end
  end

  assign q_push = s1_v_r && s1_emit_r;

endmodule

// File: sv/sobm_back.sv
// Back end: Sobel gradients, squared magnitude and a pipelined rounded root.
// Depends on sobm_pkg; feeds the result queue under a credit count.
module sobm_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  sobm_pkg::win_item_t q_data,
  output logic                q_pop,
  output logic                r_push,
  output sobm_pkg::out_item_t r_data,
  input  logic                r_pop
);

  localparam int KW = $clog2(sobm_pkg::OUT_DEPTH + 1);
  localparam int RB = sobm_pkg::ROOT_BITS;

  logic [KW-1:0] cnt_r, cnt_nxt;

  logic                     g_v_r;
  logic signed [11:0]       gx_r [3];
  logic signed [11:0]       gy_r [3];
  logic                     g_done_r;

  logic                     rv_r    [RB+1];
  logic                     rdone_r [RB+1];
  logic [15:0]              rs_r    [RB+1][3];
  logic [7:0]               rn_r    [RB+1][3];

  function automatic logic signed [11:0] ext(input logic [7:0] v);
    ext = $signed({4'b0000, v});
  endfunction

  function automatic logic [7:0] chan(input sobm_pkg::pix_t p, input int unsigned k);
    case (k)
      0:       chan = p.r;
      1:       chan = p.g;
      default: chan = p.b;
    endcase
  endfunction

  assign q_pop = !q_empty && (cnt_r < KW'(sobm_pkg::OUT_DEPTH));

  always_comb begin
    cnt_nxt = cnt_r;
    if (q_pop && !r_pop) begin
      cnt_nxt = cnt_r + KW'(1);
    end else if (!q_pop && r_pop) begin
      cnt_nxt = cnt_r - KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      g_v_r <= 1'b0;
      for (int i = 0; i <= RB; i++) begin
        rv_r[i] <= 1'b0;
      end
    end else begin
      cnt_r   <= cnt_nxt;
      g_v_r   <= q_pop;
      rv_r[0] <= g_v_r;
      for (int i = 1; i <= RB; i++) begin
        rv_r[i] <= rv_r[i-1];
      end
    end
  end

  // Gradient stage
  always_ff @(posedge clk) begin
    g_done_r <= q_data.done;
    for (int k = 0; k < 3; k++) begin
      gx_r[k] <= (ext(chan(q_data.rgt.top, k)) + (ext(chan(q_data.rgt.mid, k)) <<< 1)
                  + ext(chan(q_data.rgt.bot, k)))
               - (ext(chan(q_data.lft.top, k)) + (ext(chan(q_data.lft.mid, k)) <<< 1)
                  + ext(chan(q_data.lft.bot, k)));
      gy_r[k] <= (ext(chan(q_data.lft.bot, k)) + (ext(chan(q_data.ctr.bot, k)) <<< 1)
                  + ext(chan(q_data.rgt.bot, k)))
               - (ext(chan(q_data.lft.top, k)) + (ext(chan(q_data.ctr.top, k)) <<< 1)
                  + ext(chan(q_data.rgt.top, k)));
    end
  end

  // Squared magnitude, saturated: anything above 16 bits already rounds to 255.
  // One root bit per stage after it: the result is the largest n with n*n - n below s.
  always_ff @(posedge clk) begin
    logic [23:0] sqx;
    logic [23:0] sqy;
    logic [24:0] sum;
    logic [7:0]  t;
    logic [15:0] sq;
    rdone_r[0] <= g_done_r;
    for (int k = 0; k < 3; k++) begin
      sqx = gx_r[k] * gx_r[k];
      sqy = gy_r[k] * gy_r[k];
      sum = {1'b0, sqx} + {1'b0, sqy};
      rs_r[0][k] <= (sum > 25'd65535) ? 16'hFFFF : sum[15:0];
      rn_r[0][k] <= '0;
    end
    for (int st = 1; st <= RB; st++) begin
      rdone_r[st] <= rdone_r[st-1];
      for (int k = 0; k < 3; k++) begin
        t  = rn_r[st-1][k] | (8'd1 << (RB - st));
        sq = 16'(t * t) - {8'd0, t};
        rs_r[st][k] <= rs_r[st-1][k];
        rn_r[st][k] <= (sq < rs_r[st-1][k]) ? t : rn_r[st-1][k];
      end
    end
  end

  assign r_push            = rv_r[RB];
  assign r_data.red_edge   = rn_r[RB][0];
  assign r_data.green_edge = rn_r[RB][1];
  assign r_data.blue_edge  = rn_r[RB][2];
  assign r_data.frame_done = rdone_r[RB];

endmodule

// File: sv/sobel_edge_magnitude_rgb.sv
// Top level of the RGB Sobel edge magnitude block: configuration registers,
// front end, middle queue, back end and result queue.
// Depends on sobm_pkg, sobm_front, sobm_back, sobm_fifo and sobm_ram.
//
// Usage: pixels enter in raster order on the input queue port (in_push while
// in_full is low). Flush items (operation set) act as zero pixels; after a
// frame's last pixel, frame_width + 1 flush items drain the remaining results.
// The result for the pixel width + 1 places behind the current item appears
// on the result queue port; frame_done marks the frame's last result, after
// which a new frame begins. Results are taken with out_pop while out_empty is
// low. The configuration channel (cfg_index 0 = frame_width, 1 = frame_height)
// is always ready; any write restarts the frame and must be done while idle.
// Throughput is one item per clock while in_full is low. The result an item
// causes passes the line-store read and window assembly, the middle queue,
// the gradient, square and eight-step root pipeline, and then enters the
// result queue. When the receiver stops popping, the 16-entry result queue
// fills, the middle queue fills behind it and in_full rises; nothing is lost.
// Reset restores 640 x 480 and clears all positions and queues; the line
// store needs no clearing as rows above the frame top are masked.
module sobel_edge_magnitude_rgb #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  sobm_pkg::in_item_t  in_data,
  output logic                out_empty,
  input  logic                out_pop,
  output sobm_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [0:0]          cfg_index,
  input  logic [11:0]         cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $bits(sobm_pkg::win_item_t);
  localparam int OW = $bits(sobm_pkg::out_item_t);

  logic [10:0]   width_r;
  logic [11:0]   height_r;
  logic [CW-1:0] width_m1;
  logic [12:0]   height_eff;
  logic          cfg_wr;
  logic [31:0]   fw32;

  logic                q_push, q_pop, q_empty;
  sobm_pkg::win_item_t q_wdata, q_rdata;
  logic                r_push, r_pop;
  sobm_pkg::out_item_t r_wdata;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= sobm_pkg::WIDTH_RESET;
      height_r <= sobm_pkg::HEIGHT_RESET;
    end else if (cfg_wr) begin
      case (cfg_index)
        sobm_pkg::CFG_WIDTH_IDX:  width_r  <= cfg_data[10:0];
        sobm_pkg::CFG_HEIGHT_IDX: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // A width of zero acts as one, and widths beyond the line store are clipped.
  always_comb begin
    fw32 = {21'd0, width_r};
    if (fw32 == 32'd0) begin
      width_m1 = '0;
    end else if (fw32 > 32'(MAX_WIDTH)) begin
      width_m1 = CW'(MAX_WIDTH - 1);
    end else begin
      width_m1 = CW'(fw32 - 32'd1);
    end
  end

  assign height_eff = (height_r == 12'd0) ? 13'd1 : {1'b0, height_r};

  sobm_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .restart  (cfg_wr),
    .width_m1 (width_m1),
    .height   (height_eff),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_data   (q_wdata),
    .q_pop    (q_pop)
  );

  sobm_fifo #(
    .WIDTH (WW),
    .DEPTH (sobm_pkg::MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  sobm_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .r_push  (r_push),
    .r_data  (r_wdata),
    .r_pop   (r_pop)
  );

  assign r_pop = out_pop && !out_empty;

  sobm_fifo #(
    .WIDTH (OW),
    .DEPTH (sobm_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (r_push),
    .wdata (r_wdata),
    .pop   (out_pop),
    .rdata (out_data),
    .empty (out_empty)
  );

endmodule

// File: tb/sobel_edge_magnitude_rgb_test.sv
// Self-checking testbench for the RGB Sobel edge magnitude block.
// Depends on sobm_pkg and sobel_edge_magnitude_rgb; frames of random size are
// streamed through while a built-in line-store predictor checks every result.
module sobel_edge_magnitude_rgb_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_MAX   = 1024;
  localparam int RING_DEPTH = 2 * LINE_MAX + 3;
  localparam int SETTLE     = 40;

  logic                clk;
  logic                rst_n;
  logic                in_push;
  logic                in_full;
  sobm_pkg::in_item_t  in_data;
  logic                out_empty;
  logic                out_pop;
  sobm_pkg::out_item_t out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [0:0]          cfg_index;
  logic [11:0]         cfg_data;

  sobel_edge_magnitude_rgb dut (.*);

  // Predictor state.
  logic [23:0] pixel_ring [RING_DEPTH];
  int          ring_slot, col_pos, row_pos;
  logic [10:0] width_reg;
  logic [11:0] height_reg;

  sobm_pkg::in_item_t  pixel_q [$];
  sobm_pkg::out_item_t edge_q [$];
  int          errs, accepted, cfg_beats, send_gap, pop_gap, hold_cnt;
  bit          quiet;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int rounded_root(int s);
    int n;
    n = 0;
    while (n < 255 && n * n + n < s) n++;
    return n;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (quiet || r < 60) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // Steps the line-store model by one accepted beat and queues any result.
  function automatic void predict_edges(sobm_pkg::in_item_t it);
    int w, h, cr, cc, r, c, back, k, gx, gy, ch;
    logic [23:0] win [9];
    logic [23:0] pix;
    int kx [9] = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};
    int ky [9] = '{-1, -2, -1, 0, 0, 0, 1, 2, 1};
    int mag [3];
    bit emit, done;
    sobm_pkg::out_item_t res;
    w = (width_reg == 0) ? 1 : (width_reg > LINE_MAX) ? LINE_MAX : int'(width_reg);
    h = (height_reg == 0) ? 1 : int'(height_reg);
    pix = (it.operation == sobm_pkg::OP_PIXEL) ? {it.red_in, it.green_in, it.blue_in}
                                               : 24'd0;
    pixel_ring[ring_slot] = pix;
    done = 1'b0;
    emit = row_pos >= 2 || (row_pos == 1 && col_pos >= 1);
    if (emit) begin
      if (col_pos >= 1) begin
        cc = col_pos - 1;
        cr = row_pos - 1;
      end else begin
        cc = w - 1;
        cr = row_pos - 2;
      end
      for (int dr = -1; dr <= 1; dr++) begin
        for (int dc = -1; dc <= 1; dc++) begin
          r = cr + dr;
          c = cc + dc;
          k = (dr + 1) * 3 + dc + 1;
          win[k] = 24'd0;
          if (r >= 0 && r < h && c >= 0 && c < w) begin
            back = w + 1 - dr * w - dc;
            win[k] = pixel_ring[(ring_slot - back + RING_DEPTH) % RING_DEPTH];
          end
        end
      end
      for (ch = 0; ch < 3; ch++) begin
        gx = 0;
        gy = 0;
        for (k = 0; k < 9; k++) begin
          gx += kx[k] * int'((win[k] >> (16 - 8 * ch)) & 24'hFF);
          gy += ky[k] * int'((win[k] >> (16 - 8 * ch)) & 24'hFF);
        end
        mag[ch] = rounded_root(gx * gx + gy * gy);
      end
      done = (cr == h - 1 && cc == w - 1);
      res.red_edge   = mag[0][7:0];
      res.green_edge = mag[1][7:0];
      res.blue_edge  = mag[2][7:0];
      res.frame_done = done;
      edge_q.push_back(res);
    end
    ring_slot = (ring_slot + 1) % RING_DEPTH;
    if (done) begin
      col_pos = 0;
      row_pos = 0;
    end else begin
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
      end
    end
  endfunction

  // Pixel driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_push && !in_full) begin
        predict_edges(in_data);
        accepted++;
      end
      if (in_push && in_full) begin
        // Hold the beat until the block takes it.
      end else if (send_gap > 0) begin
        send_gap--;
        in_push <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        in_push <= 1'b1;
        in_data <= pixel_q.pop_front();
        send_gap = pick_gap();
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // Long receiver hold-off once the stream is well under way.
  always @(posedge clk) begin
    if (!rst_n) hold_cnt <= 0;
    else if (accepted == 600 && in_push && !in_full) hold_cnt <= 400;
    else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
      pop_gap = 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (edge_q.size() == 0) begin
          $error("result beat with nothing expected: %p", out_data);
          errs++;
        end else begin
          sobm_pkg::out_item_t exp_res;
          exp_res = edge_q.pop_front();
          if (out_data.red_edge !== exp_res.red_edge) begin
            $error("red_edge expected %0d got %0d", exp_res.red_edge, out_data.red_edge);
            errs++;
          end
          if (out_data.green_edge !== exp_res.green_edge) begin
            $error("green_edge expected %0d got %0d", exp_res.green_edge,
                   out_data.green_edge);
            errs++;
          end
          if (out_data.blue_edge !== exp_res.blue_edge) begin
            $error("blue_edge expected %0d got %0d", exp_res.blue_edge, out_data.blue_edge);
            errs++;
          end
          if (out_data.frame_done !== exp_res.frame_done) begin
            $error("frame_done expected %0d got %0d", exp_res.frame_done,
                   out_data.frame_done);
            errs++;
          end
        end
        pop_gap = pick_gap();
      end
      if (hold_cnt > 0) begin
        out_pop <= 1'b0;
      end else if (pop_gap > 0) begin
        pop_gap--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // Register writes take effect in the predictor on the accepting edge.
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      if (cfg_index == sobm_pkg::CFG_WIDTH_IDX) width_reg = cfg_data[10:0];
      else height_reg = cfg_data;
      col_pos = 0;
      row_pos = 0;
      cfg_beats++;
      cfg_valid <= 1'b0;
    end
  end

  task automatic settle();
    wait (pixel_q.size() == 0 && !in_push && edge_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, int value);
    int seen;
    seen = cfg_beats;
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[11:0];
    wait (cfg_beats != seen);
  endtask

  task automatic add_item(logic op, logic [23:0] rgb);
    sobm_pkg::in_item_t it;
    it.operation = op;
    {it.red_in, it.green_in, it.blue_in} = rgb;
    pixel_q.push_back(it);
  endtask

  // Queues one frame plus its drain; noisy frames get stray flushes, and a
  // truncated frame stops part-way, with no drain, so the next register write restarts it.
  task automatic add_frame(int w, int h, bit noisy, bit truncate);
    int n, style;
    logic [23:0] rgb;
    n = truncate ? $urandom_range(w * h) : w * h;
    style = $urandom_range(2);
    for (int i = 0; i < n; i++) begin
      if (style == 0) rgb = $urandom();
      else if (style == 1) rgb = $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
      else rgb = {3{$urandom_range(1) ? 8'hFF : 8'h00}} ^ ($urandom() & 24'h0F0F0F);
      add_item((noisy && $urandom_range(9) == 0) ? sobm_pkg::OP_FLUSH : sobm_pkg::OP_PIXEL,
               rgb);
    end
    if (!truncate) for (int i = 0; i <= w; i++) add_item(sobm_pkg::OP_FLUSH, $urandom());
  endtask

  initial begin
    int w, h, frames, rand_items;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_data = '0;
    out_pop = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = sobm_pkg::CFG_WIDTH_IDX;
    cfg_data = '0;
    errs = 0;
    accepted = 0;
    cfg_beats = 0;
    quiet = 1'b0;
    width_reg = sobm_pkg::WIDTH_RESET;
    height_reg = sobm_pkg::HEIGHT_RESET;
    ring_slot = 0;
    col_pos = 0;
    row_pos = 0;
    foreach (pixel_ring[i]) pixel_ring[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: a 3 x 3 frame of extremes, a flush inside the frame, junk
    // on flush beats that must be masked, then a uniformly white frame.
    write_reg(sobm_pkg::CFG_WIDTH_IDX, 3);
    write_reg(sobm_pkg::CFG_HEIGHT_IDX, 3);
    add_item(sobm_pkg::OP_PIXEL, 24'hFFFFFF);
    add_item(sobm_pkg::OP_PIXEL, 24'h000000);
    add_item(sobm_pkg::OP_PIXEL, 24'hFF00FF);
    add_item(sobm_pkg::OP_PIXEL, 24'h00FF00);
    add_item(sobm_pkg::OP_FLUSH, 24'hFFFFFF);
    add_item(sobm_pkg::OP_PIXEL, 24'hAA55AA);
    add_item(sobm_pkg::OP_PIXEL, 24'h55AA55);
    add_item(sobm_pkg::OP_PIXEL, 24'h000000);
    add_item(sobm_pkg::OP_PIXEL, 24'hFFFFFF);
    repeat (4) add_item(sobm_pkg::OP_FLUSH, 24'hFFFFFF);
    repeat (9) add_item(sobm_pkg::OP_PIXEL, 24'hFFFFFF);
    repeat (4) add_item(sobm_pkg::OP_FLUSH, 24'h000000);
    settle();

    // Zero registers act as a 1 x 1 frame.
    write_reg(sobm_pkg::CFG_WIDTH_IDX, 0);
    write_reg(sobm_pkg::CFG_HEIGHT_IDX, 0);
    add_frame(1, 1, 0, 0);
    add_frame(1, 1, 0, 0);
    settle();

    // Tall frame, one pixel wide.
    write_reg(sobm_pkg::CFG_WIDTH_IDX, 1);
    write_reg(sobm_pkg::CFG_HEIGHT_IDX, 300);
    add_frame(1, 300, 0, 0);
    settle();

    // Width beyond the line store clamps to the maximum: results start one
    // line and one pixel in, and the frame is cut short there.
    write_reg(sobm_pkg::CFG_WIDTH_IDX, 2047);
    write_reg(sobm_pkg::CFG_HEIGHT_IDX, 2);
    quiet = 1'b1;
    for (int i = 0; i < LINE_MAX + 16; i++) add_item(sobm_pkg::OP_PIXEL, 24'($urandom()));
    settle();
    quiet = 1'b0;

    rand_items = 0;
    while (rand_items < 100) begin
      w = ($urandom_range(9) != 0) ? $urandom_range(8, 1) : $urandom_range(40, 9);
      h = $urandom_range(6, 1);
      case ($urandom_range(2))
        0: write_reg(sobm_pkg::CFG_WIDTH_IDX, w);
        1: write_reg(sobm_pkg::CFG_HEIGHT_IDX, h);
        default: begin
          write_reg(sobm_pkg::CFG_WIDTH_IDX, w);
          write_reg(sobm_pkg::CFG_HEIGHT_IDX, h);
        end
      endcase
      w = (width_reg == 0) ? 1 : (width_reg > LINE_MAX) ? LINE_MAX : int'(width_reg);
      h = (height_reg == 0) ? 1 : int'(height_reg);
      frames = $urandom_range(3, 1);
      quiet = ($urandom_range(4) == 0);
      for (int f = 0; f < frames; f++) begin
        add_frame(w, h, $urandom_range(4) == 0, f == frames - 1 && $urandom_range(9) == 0);
        rand_items += w * h + w + 1;
      end
      settle();
    end

    if (errs == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
